[design/two_button_timed_debouncer_core_assert.svh]
// Assertion macros shared by the debouncer modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TWO_BUTTON_TIMED_DEBOUNCER_CORE_ASSERT_SVH
`define TWO_BUTTON_TIMED_DEBOUNCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tbd_pkg.sv]
`default_nettype none

package tbd_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 16;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd20;

  // Per-button debounce mode
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_PRESS_DEB  = 3'd1,
    MODE_PRESS_CONF = 3'd2,
    MODE_HELD       = 3'd3,
    MODE_REL_DEB    = 3'd4,
    MODE_REL_CONF   = 3'd5
  } mode_t;

  // Events found by one lane on the current item
  typedef struct packed {
    logic press;
    logic release_ev;
  } lane_evt_t;

  // One result item
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              release_b;
    logic              press_b;
    logic              release_a;
    logic              press_a;
  } result_t;

endpackage

`default_nettype wire

[design/tbd_lane.sv]
`default_nettype none
`include "two_button_timed_debouncer_core_assert.svh"

module tbd_lane (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_i,
  input  wire logic                         down_i,
  input  wire logic [tbd_pkg::TIME_W-1:0]   time_i,
  input  wire logic [tbd_pkg::DELAY_W-1:0]  delay_i,
  output tbd_pkg::lane_evt_t                evt_o
);
  import tbd_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              settled;

  // Elapsed time wraps modulo 2^32
  assign elapsed = time_i - since_r;
  assign settled = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay_i};

  // Hold mode and last-transition time; advance only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      since_r <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      since_r <= since_nxt;
    end
  end

  // Next mode, timestamp and events
  always_comb begin
    mode_nxt         = mode_r;
    since_nxt        = since_r;
    evt_o.press      = 1'b0;
    evt_o.release_ev = 1'b0;
    unique case (mode_r)
      MODE_PRESS_DEB: begin
        if (!down_i) begin
          mode_nxt  = MODE_IDLE;
          since_nxt = time_i;
        end else if (settled) begin
          mode_nxt    = MODE_PRESS_CONF;
          evt_o.press = 1'b1;
        end
      end
      MODE_PRESS_CONF, MODE_HELD: begin
        if (down_i) begin
          mode_nxt = MODE_HELD;
        end else begin
          mode_nxt  = MODE_REL_DEB;
          since_nxt = time_i;
        end
      end
      MODE_REL_DEB: begin
        if (down_i) begin
          mode_nxt  = MODE_PRESS_DEB;
          since_nxt = time_i;
        end else if (settled) begin
          mode_nxt         = MODE_REL_CONF;
          since_nxt        = time_i;
          evt_o.release_ev = 1'b1;
        end
      end
      MODE_REL_CONF: begin
        mode_nxt = down_i ? MODE_PRESS_DEB : MODE_IDLE;
      end
      default: begin
        // Idle, and any code that cannot be reached
        since_nxt = time_i;
        mode_nxt  = down_i ? MODE_PRESS_DEB : MODE_IDLE;
      end
    endcase
  end

  `TBD_ASSERT_NOW(a_one_event, 1'b1, !(evt_o.press && evt_o.release_ev), "press and release together")
  `TBD_ASSERT_NEXT(a_press_conf, step_i && evt_o.press, mode_r == MODE_PRESS_CONF, "press not confirmed")
  `TBD_ASSERT_NEXT(a_rel_stamp, step_i && evt_o.release_ev, since_r == $past(time_i), "release time not kept")

endmodule

`default_nettype wire

[design/tbd_merge.sv]
`default_nettype none
`include "two_button_timed_debouncer_core_assert.svh"

module tbd_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire tbd_pkg::lane_evt_t          evt_a_i,
  input  wire tbd_pkg::lane_evt_t          evt_b_i,
  input  wire logic [tbd_pkg::TIME_W-1:0]  time_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tbd_pkg::result_t                 out_res_o
);
  import tbd_pkg::*;

  result_t res_in;
  result_t out_res_r, skid_res_r;
  logic    out_valid_r, skid_valid_r;
  logic    accept;
  logic    out_free;

  // Combine lane events with the sample time
  always_comb begin
    res_in.press_a   = evt_a_i.press;
    res_in.release_a = evt_a_i.release_ev;
    res_in.press_b   = evt_b_i.press;
    res_in.release_b = evt_b_i.release_ev;
    res_in.time_ms   = time_i;
  end

  assign in_ready_o  = !skid_valid_r;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_r || out_ready_i;
  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_res_r;

  // Output register backed by one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : res_in;
    end
    if (!out_free && accept) begin
      skid_res_r <= res_in;
    end
  end

  `TBD_ASSERT_NOW(a_skid_order, skid_valid_r, out_valid_r, "skid entry without output entry")
  `TBD_ASSERT_NEXT(a_no_drop, accept && out_valid_r && !out_ready_i, skid_valid_r && (skid_res_r == $past(res_in)), "stalled item lost")

endmodule

`default_nettype wire

[design/two_button_timed_debouncer_core.sv]
`default_nettype none
// Channel | Direction | Handshake              | Payload
// in      | input     | in_tvalid / in_tready   | in_tdata: raw_a, raw_b, event_time_ms
// out     | output    | out_tvalid / out_tready | out_tdata: press/release A, B, result_time_ms
// cfg     | input     | cfg_valid / cfg_ready   | cfg_data: debounce_delay_ms
//
// One item per clock while in_tready is high: each button lane does one wrapped subtract and compare per item.
// An accepted item's result is registered in the output register, or in the skid entry while the output stalls.
// An output stall is absorbed by a one-entry skid; in_tready drops only when it fills.
// Reset (rst_n low, synchronous) puts both buttons in idle, clears stored times,
// and sets the debounce delay to 20 ms. cfg_ready is always high.

module two_button_timed_debouncer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // [0] raw_a, [1] raw_b, [33:2] event_time_ms, [39:34] zero
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] press_a, [1] release_a, [2] press_b, [3] release_b, [35:4] result_time_ms,
  // [39:36] zero
  output logic      [39:0] out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);
  import tbd_pkg::*;

  logic [DELAY_W-1:0] delay_r;
  logic               step;
  logic [TIME_W-1:0]  sample_time;
  lane_evt_t          evt_a, evt_b;
  result_t            res;

  assign cfg_ready   = 1'b1;
  assign sample_time = in_tdata[TIME_W+1:2];
  assign step        = in_tvalid && in_tready;

  // Hold the debounce delay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_r <= cfg_data;
    end
  end

  // One lane per button
  tbd_lane u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .down_i  (in_tdata[0]),
    .time_i  (sample_time),
    .delay_i (delay_r),
    .evt_o   (evt_a)
  );

  tbd_lane u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .down_i  (in_tdata[1]),
    .time_i  (sample_time),
    .delay_i (delay_r),
    .evt_o   (evt_b)
  );

  // Merge lane events into one result item
  tbd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .evt_a_i     (evt_a),
    .evt_b_i     (evt_b),
    .time_i      (sample_time),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (res)
  );

  assign out_tdata = {4'b0000, res.time_ms, res.release_b, res.press_b,
                      res.release_a, res.press_a};

endmodule

`default_nettype wire

[tb/two_button_timed_debouncer_core_test.sv]
`default_nettype none

module two_button_timed_debouncer_core_test;
  import tbd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE_TICKS = 4;

  // Tracks both button machines and holds the results still owed by the block
  class debounce_scoreboard;
    mode_t              mode_q[2];
    logic [TIME_W-1:0]  since_q[2];
    logic [DELAY_W-1:0] delay_ms;
    result_t            owed_q[$];
    int unsigned        mismatches;

    function new();
      mode_q[0]  = MODE_IDLE;
      mode_q[1]  = MODE_IDLE;
      since_q[0] = '0;
      since_q[1] = '0;
      delay_ms   = DELAY_RESET;
      mismatches = 0;
    endfunction

    function void set_delay(logic [DELAY_W-1:0] value);
      delay_ms = value;
    endfunction

    // Advance one button by one sample
    function void step_button(int idx, logic down, logic [TIME_W-1:0] now,
                              output logic pressed, output logic released);
      logic [TIME_W-1:0] elapsed;
      logic              settled;
      elapsed  = now - since_q[idx];
      settled  = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay_ms};
      pressed  = 1'b0;
      released = 1'b0;
      case (mode_q[idx])
        MODE_PRESS_DEB: begin
          if (!down) begin
            mode_q[idx]  = MODE_IDLE;
            since_q[idx] = now;
          end else if (settled) begin
            mode_q[idx] = MODE_PRESS_CONF;
            pressed     = 1'b1;
          end
        end
        MODE_PRESS_CONF, MODE_HELD: begin
          if (down) begin
            mode_q[idx] = MODE_HELD;
          end else begin
            mode_q[idx]  = MODE_REL_DEB;
            since_q[idx] = now;
          end
        end
        MODE_REL_DEB: begin
          if (down) begin
            mode_q[idx]  = MODE_PRESS_DEB;
            since_q[idx] = now;
          end else if (settled) begin
            mode_q[idx]  = MODE_REL_CONF;
            since_q[idx] = now;
            released     = 1'b1;
          end
        end
        MODE_REL_CONF: begin
          mode_q[idx] = down ? MODE_PRESS_DEB : MODE_IDLE;
        end
        default: begin
          since_q[idx] = now;
          mode_q[idx]  = down ? MODE_PRESS_DEB : MODE_IDLE;
        end
      endcase
    endfunction

    // Button A is stepped before button B
    function void note_input(logic raw_a, logic raw_b, logic [TIME_W-1:0] now);
      result_t res;
      logic    p, r;
      step_button(0, raw_a, now, p, r);
      res.press_a   = p;
      res.release_a = r;
      step_button(1, raw_b, now, p, r);
      res.press_b   = p;
      res.release_b = r;
      res.time_ms   = now;
      owed_q.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result with nothing owed, got %h", got);
      end else begin
        want = owed_q.pop_front();
        if (got.press_a !== want.press_a || got.release_a !== want.release_a ||
            got.press_b !== want.press_b || got.release_b !== want.release_b ||
            got.time_ms !== want.time_ms) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pa/ra/pb/rb/t expected %b%b%b%b %h, actual %b%b%b%b %h",
                     want.press_a, want.release_a, want.press_b, want.release_b,
                     want.time_ms, got.press_a, got.release_a, got.press_b,
                     got.release_b, got.time_ms);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function int unsigned failures();
      return mismatches + owed_q.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [39:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] cfg_data   = '0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;

  debounce_scoreboard sb = new();

  logic [TIME_W-1:0] now_ms      = '0;
  bit                tx_idle_on  = 1'b1;
  int unsigned       tx_burst    = 0;
  bit                rx_hold_req = 1'b0;

  two_button_timed_debouncer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #4 clk = ~clk;

  // Offer one sample after a random gap and hold it until accepted
  task automatic send_item(logic raw_a, logic raw_b, logic [TIME_W-1:0] stamp);
    int unsigned gap;
    if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else begin
      gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'b0, stamp, raw_b, raw_a};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(raw_a, raw_b, stamp);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write the delay only once the block is idle
  task automatic write_delay(logic [DELAY_W-1:0] value);
    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_delay(value);
  endtask

  // Random samples: level runs with glitches, time steps scaled to the delay
  task automatic run_phase(int unsigned count);
    logic        lvl_a, lvl_b, a, b;
    int unsigned run_a, run_b, pick, span;
    lvl_a = 1'b0;
    lvl_b = 1'b0;
    run_a = 0;
    run_b = 0;
    span  = sb.delay_ms;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 60 == 0)
        tx_idle_on = ($urandom_range(0, 2) != 0);
      if (run_a == 0) begin
        lvl_a = 1'($urandom_range(0, 1));
        run_a = $urandom_range(1, 8);
      end
      if (run_b == 0) begin
        lvl_b = 1'($urandom_range(0, 1));
        run_b = $urandom_range(1, 8);
      end
      run_a--;
      run_b--;
      a = lvl_a ^ ($urandom_range(0, 19) == 0);
      b = lvl_b ^ ($urandom_range(0, 19) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 4)
        now_ms = $urandom();
      else if (pick < 6)
        now_ms = 32'hFFFF_FFFF - $urandom_range(0, span + 8);
      else if (pick < 8)
        now_ms = now_ms - $urandom_range(1, span + 8);
      else if (pick < 25)
        now_ms = now_ms + $urandom_range(span, 2 * span + 4);
      else
        now_ms = now_ms + $urandom_range(0, span / 2 + 2);
      send_item(a, b, now_ms);
    end
  endtask

  // Receiver: random stalls, runs without stalls, and one long hold-off on request
  initial begin : result_sink
    int unsigned wait_cycles;
    int unsigned taken;
    bit          rx_idle_on;
    taken      = 0;
    rx_idle_on = 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 64 == 0)
        rx_idle_on = ($urandom_range(0, 2) != 0);
      wait_cycles = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (rx_hold_req) begin
        wait_cycles = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Check each accepted result and watch for a stalled run
  initial begin : result_check
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        sb.check_result(result_t'(out_tdata[35:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready) || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("stall: no item moved for %0d cycles", STALL_LIMIT);
    $display("two_button_timed_debouncer_core_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full press and release cycles at the reset delay of 20
    send_item(1'b0, 1'b0, 32'd0);
    send_item(1'b1, 1'b0, 32'd5);
    send_item(1'b1, 1'b0, 32'd10);
    send_item(1'b0, 1'b0, 32'd12);
    send_item(1'b1, 1'b1, 32'd20);
    send_item(1'b1, 1'b1, 32'd40);
    send_item(1'b1, 1'b1, 32'd41);
    send_item(1'b0, 1'b1, 32'd50);
    send_item(1'b1, 1'b1, 32'd55);
    send_item(1'b1, 1'b0, 32'd80);
    send_item(1'b0, 1'b0, 32'd90);
    send_item(1'b0, 1'b0, 32'd120);
    send_item(1'b1, 1'b1, 32'd121);
    send_item(1'b0, 1'b0, 32'd122);
    // Timestamp wrap through zero and a step backwards
    send_item(1'b1, 1'b1, 32'hFFFF_FFF0);
    send_item(1'b1, 1'b1, 32'h0000_0004);
    send_item(1'b0, 1'b0, 32'h0000_0005);
    send_item(1'b0, 1'b0, 32'h0000_0001);
    send_item(1'b0, 1'b0, 32'hFFFF_FFFF);
    // Zero delay confirms on the next sample
    write_delay(16'd0);
    send_item(1'b1, 1'b0, 32'hAAAA_5555);
    send_item(1'b1, 1'b1, 32'hAAAA_5555);
    send_item(1'b0, 1'b1, 32'h5555_AAAA);
    send_item(1'b0, 1'b0, 32'h5555_AAAA);
    write_delay(16'hFFFF);
    send_item(1'b1, 1'b1, 32'h0000_0000);
    send_item(1'b1, 1'b1, 32'h0000_FFFF);

    // Reset delay with back pressure and a full drain in the middle
    write_delay(DELAY_RESET);
    now_ms = $urandom();
    run_phase(100);
    rx_hold_req = 1'b1;
    tx_burst    = 40;
    run_phase(100);
    drain_results();
    run_phase(50);

    write_delay(16'd0);
    run_phase(200);
    write_delay(16'hFFFF);
    run_phase(200);
    write_delay(16'd1);
    run_phase(200);
    write_delay(DELAY_W'($urandom_range(2, 300)));
    run_phase(200);
    write_delay(DELAY_W'($urandom()));
    run_phase(150);
    write_delay(16'd7);
    run_phase(150);

    drain_results();
    repeat (SETTLE_TICKS + 4) @(posedge clk);
    if (sb.failures() == 0)
      $display("two_button_timed_debouncer_core_test: done, clean");
    else
      $display("two_button_timed_debouncer_core_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
